### hdl/tfd_pkg.sv
// Shared types and constants for the typed frame deframer.
package tfd_pkg;

  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEtx = 8'h03;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] TagBool = 8'h71;
  localparam logic [3:0] NibSize = 4'h0F;

  typedef enum logic [3:0] {
    PH_SOH, PH_LTAG, PH_LEN, PH_STX, PH_CMD, PH_ATAG, PH_AVAL,
    PH_BLEN, PH_BBODY, PH_ETX, PH_CHK, PH_EOT, PH_HALT
  } phase_e;

  typedef enum logic [2:0] {
    EV_CMD = 3'd0, EV_SCALAR = 3'd1, EV_BSTART = 3'd2, EV_BBYTE = 3'd3,
    EV_OK = 3'd4, EV_ERR = 3'd5
  } event_e;

  typedef enum logic [2:0] {
    AT_INT = 3'd0, AT_F32 = 3'd1, AT_F64 = 3'd2, AT_BOOL = 3'd3,
    AT_STR = 3'd4, AT_BYTES = 3'd5
  } arg_e;

  typedef enum logic [3:0] {
    ER_NONE = 4'd0, ER_SOH = 4'd1, ER_LTAG = 4'd2, ER_STX = 4'd3, ER_ETX = 4'd4,
    ER_ATAG = 4'd5, ER_CHK = 4'd6, ER_EOT = 4'd7, ER_LEN = 4'd8
  } err_e;

  localparam logic CfgMaxLen = 1'b0;
  localparam logic CfgStop = 1'b1;

  typedef struct packed {
    logic [2:0]  kind;
    logic [2:0]  atype;
    logic [63:0] value;
    logic        last;
    logic [3:0]  err;
  } evt_t;

endpackage

### hdl/tfd_front.sv
// Front: byte parser state machine that produces result events.
module tfd_front #(
  parameter int LEN_BITS = 31
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             byte_valid_i,
  input  logic [7:0]       byte_i,
  output logic             byte_stall_o,
  input  logic [30:0]      max_text_len_i,
  input  logic             stop_on_error_i,
  output logic             evt_valid_o,
  output tfd_pkg::evt_t    evt_o,
  input  logic             evt_room_i
);
  import tfd_pkg::*;

  localparam logic [31:0] LenMax = 32'((64'd1 << LEN_BITS) - 64'd1);

  phase_e      phase_q, phase_d;
  logic [3:0]  cnt_q, cnt_d;
  logic [31:0] lacc_q, lacc_d;
  logic [30:0] trem_q, trem_d;
  logic [7:0]  chk_q, chk_d;
  logic [7:0]  tag_q, tag_d;
  logic [63:0] vacc_q, vacc_d;
  logic [30:0] brem_q, brem_d;
  logic        fire;
  logic [30:0] trem_dec;
  logic [3:0]  cnt_dec;
  logic [31:0] lacc_sh;
  logic [63:0] vacc_sh, sext;
  logic        lneg;
  logic [3:0]  asz, tsz;
  logic        in_text;
  phase_e      after_item;
  logic [2:0]  blob_type;

  assign byte_stall_o = !evt_room_i;
  assign fire = byte_valid_i && evt_room_i;

  always_comb begin
    in_text = (phase_q == PH_CMD) || (phase_q == PH_ATAG) || (phase_q == PH_AVAL) ||
              (phase_q == PH_BLEN) || (phase_q == PH_BBODY);
    trem_dec = in_text ? trem_q - 31'd1 : trem_q;
    after_item = (trem_dec == '0) ? PH_ETX : PH_ATAG;
    cnt_dec = cnt_q - 4'd1;
    lacc_sh = {lacc_q[23:0], byte_i};
    vacc_sh = {vacc_q[55:0], byte_i};
    tsz = tag_q[3:0];
    // argument size: low tag nibble, one byte for a boolean
    asz = (byte_i == TagBool) ? 4'd1 : byte_i[3:0];
    unique case (tsz)
      4'd1:    lneg = lacc_sh[7];
      4'd2:    lneg = lacc_sh[15];
      4'd4:    lneg = lacc_sh[31];
      default: lneg = lacc_sh[0];
    endcase
    unique case (tsz)
      4'd1:    sext = {{56{vacc_sh[7]}}, vacc_sh[7:0]};
      4'd2:    sext = {{48{vacc_sh[15]}}, vacc_sh[15:0]};
      4'd4:    sext = {{32{vacc_sh[31]}}, vacc_sh[31:0]};
      default: sext = vacc_sh;
    endcase
    blob_type = (tag_q >= 8'hB0) ? AT_BYTES : AT_STR;
  end

  always_comb begin
    phase_d = phase_q; cnt_d = cnt_q; lacc_d = lacc_q; trem_d = trem_q;
    chk_d = chk_q; tag_d = tag_q; vacc_d = vacc_q; brem_d = brem_q;
    evt_valid_o = 1'b0;
    evt_o = '0;
    if (fire) begin
      trem_d = trem_dec;
      if (in_text) chk_d = chk_q ^ byte_i;
      unique case (phase_q)
        PH_HALT: begin
          if (!stop_on_error_i && byte_i == ChSoh) phase_d = PH_LTAG;
        end
        PH_SOH: begin
          if (byte_i != ChSoh) begin
            evt_valid_o = 1'b1; evt_o.kind = EV_ERR; evt_o.err = ER_SOH;
            phase_d = PH_HALT;
          end else phase_d = PH_LTAG;
        end
        PH_LTAG: begin
          if (byte_i != 8'h11 && byte_i != 8'h12 && byte_i != 8'h14) begin
            evt_valid_o = 1'b1; evt_o.kind = EV_ERR; evt_o.err = ER_LTAG;
            phase_d = PH_HALT;
          end else begin
            tag_d = byte_i; cnt_d = byte_i[3:0] & NibSize; lacc_d = '0;
            phase_d = PH_LEN;
          end
        end
        PH_LEN: begin
          lacc_d = lacc_sh; cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            if (lneg || lacc_sh == '0 || lacc_sh > {1'b0, max_text_len_i} ||
                lacc_sh > LenMax) begin
              evt_valid_o = 1'b1; evt_o.kind = EV_ERR; evt_o.err = ER_LEN;
              phase_d = PH_HALT;
            end else begin
              trem_d = lacc_sh[30:0]; chk_d = '0; phase_d = PH_STX;
            end
          end
        end
        PH_STX: begin
          if (byte_i != ChStx) begin
            evt_valid_o = 1'b1; evt_o.kind = EV_ERR; evt_o.err = ER_STX;
            phase_d = PH_HALT;
          end else phase_d = PH_CMD;
        end
        PH_CMD: begin
          phase_d = after_item;
          evt_valid_o = 1'b1; evt_o.kind = EV_CMD; evt_o.value = {56'd0, byte_i};
        end
        PH_ATAG: begin
          if (byte_i == 8'h31 || byte_i == 8'h32 || byte_i == 8'h34 || byte_i == 8'h38 ||
              byte_i == 8'h54 || byte_i == 8'h58 || byte_i == TagBool ||
              byte_i == 8'h91 || byte_i == 8'h92 || byte_i == 8'h94 ||
              byte_i == 8'hB1 || byte_i == 8'hB2 || byte_i == 8'hB4) begin
            if ({27'd0, asz} > trem_dec) begin
              evt_valid_o = 1'b1; evt_o.kind = EV_ERR; evt_o.err = ER_LEN;
              phase_d = PH_HALT;
            end else begin
              tag_d = byte_i; cnt_d = asz;
              if (byte_i[7]) begin
                lacc_d = '0; phase_d = PH_BLEN;
              end else begin
                vacc_d = '0; phase_d = PH_AVAL;
              end
            end
          end else begin
            evt_valid_o = 1'b1; evt_o.kind = EV_ERR; evt_o.err = ER_ATAG;
            phase_d = PH_HALT;
          end
        end
        PH_AVAL: begin
          vacc_d = vacc_sh; cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            phase_d = after_item;
            evt_valid_o = 1'b1; evt_o.kind = EV_SCALAR;
            priority if (tag_q[7:4] == 4'h3) begin
              evt_o.atype = AT_INT; evt_o.value = sext;
            end else if (tag_q[7:4] == 4'h5) begin
              evt_o.atype = (tsz == 4'd4) ? AT_F32 : AT_F64; evt_o.value = vacc_sh;
            end else begin
              evt_o.atype = AT_BOOL; evt_o.value = {63'd0, vacc_sh[7:0] != '0};
            end
          end
        end
        PH_BLEN: begin
          lacc_d = lacc_sh; cnt_d = cnt_dec;
          if (cnt_dec == '0) begin
            evt_valid_o = 1'b1;
            if (lneg || lacc_sh > {1'b0, trem_dec}) begin
              evt_o.kind = EV_ERR; evt_o.err = ER_LEN; phase_d = PH_HALT;
            end else begin
              brem_d = lacc_sh[30:0];
              phase_d = (lacc_sh != '0) ? PH_BBODY : after_item;
              evt_o.kind = EV_BSTART; evt_o.atype = blob_type;
              evt_o.value = {32'd0, lacc_sh};
            end
          end
        end
        PH_BBODY: begin
          brem_d = brem_q - 31'd1;
          if (brem_d == '0) phase_d = after_item;
          evt_valid_o = 1'b1; evt_o.kind = EV_BBYTE; evt_o.atype = blob_type;
          evt_o.value = {56'd0, byte_i}; evt_o.last = (brem_d == '0);
        end
        PH_ETX: begin
          if (byte_i != ChEtx) begin
            evt_valid_o = 1'b1; evt_o.kind = EV_ERR; evt_o.err = ER_ETX;
            phase_d = PH_HALT;
          end else phase_d = PH_CHK;
        end
        PH_CHK: begin
          if (byte_i != chk_q) begin
            evt_valid_o = 1'b1; evt_o.kind = EV_ERR; evt_o.err = ER_CHK;
            phase_d = PH_HALT;
          end else phase_d = PH_EOT;
        end
        PH_EOT: begin
          evt_valid_o = 1'b1;
          if (byte_i != ChEot) begin
            evt_o.kind = EV_ERR; evt_o.err = ER_EOT; phase_d = PH_HALT;
          end else begin
            evt_o.kind = EV_OK; phase_d = PH_SOH;
          end
        end
        default: phase_d = PH_SOH;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SOH; cnt_q <= '0; lacc_q <= '0; trem_q <= '0; chk_q <= '0;
      tag_q <= '0; vacc_q <= '0; brem_q <= '0;
    end else begin
      phase_q <= phase_d; cnt_q <= cnt_d; lacc_q <= lacc_d; trem_q <= trem_d;
      chk_q <= chk_d; tag_q <= tag_d; vacc_q <= vacc_d; brem_q <= brem_d;
    end
  end
endmodule

### hdl/tfd_queue.sv
// Back: two-entry event queue feeding the output channel.
module tfd_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tfd_pkg::evt_t data_i,
  output logic          room_o,
  output logic          valid_o,
  output tfd_pkg::evt_t data_o,
  input  logic          stall_i
);
  import tfd_pkg::*;

  evt_t       mem_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       pop;

  assign valid_o = cnt_q != 2'd0;
  assign room_o  = cnt_q != 2'd2;
  assign data_o  = mem_q[rp_q];
  assign pop     = valid_o && !stall_i;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= !wp_q;
      if (pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop);
    end
  end
endmodule

### hdl/typed_frame_deframer_unit.sv
// Top level of the typed frame deframer: config registers, parser, event queue.
//
//  channel | direction | handshake           | payload
//  rx      | in        | rx_valid_i/rx_stall_o | rx_byte_i
//  evt     | out       | evt_valid_o/evt_stall_i | event_kind_o .. error_code_o
//  cfg     | in        | cfg_we_i            | cfg_index_i, cfg_data_i
//
// One byte per cycle sustained while the queue has room; each result is registered
// into the queue at its byte's transfer. A two-entry queue separates parser and
// output, so rx stalls only when the queue is full. Reset clears the parser,
// empties the queue and puts max_text_len at its maximum and stop_on_error at 1.
module typed_frame_deframer_unit #(
  parameter int LEN_BITS = 31
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        rx_valid_i,
  output logic        rx_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        evt_valid_o,
  input  logic        evt_stall_i,
  output logic [2:0]  event_kind_o,
  output logic [2:0]  arg_type_o,
  output logic [63:0] value_o,
  output logic        last_blob_byte_o,
  output logic [3:0]  error_code_o,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [30:0] cfg_data_i
);
  import tfd_pkg::*;

  logic [30:0] max_len_q;
  logic        stop_q;
  logic        fe_valid, room;
  evt_t        fe_evt, q_evt;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= '1;
      stop_q    <= 1'b1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgMaxLen) max_len_q <= cfg_data_i;
      else stop_q <= cfg_data_i[0];
    end
  end

  tfd_front #(.LEN_BITS(LEN_BITS)) u_front (
    .clk_i, .rst_ni,
    .byte_valid_i(rx_valid_i), .byte_i(rx_byte_i), .byte_stall_o(rx_stall_o),
    .max_text_len_i(max_len_q), .stop_on_error_i(stop_q),
    .evt_valid_o(fe_valid), .evt_o(fe_evt), .evt_room_i(room)
  );

  tfd_queue u_queue (
    .clk_i, .rst_ni, .push_i(fe_valid), .data_i(fe_evt), .room_o(room),
    .valid_o(evt_valid_o), .data_o(q_evt), .stall_i(evt_stall_i)
  );

  assign event_kind_o     = q_evt.kind;
  assign arg_type_o       = q_evt.atype;
  assign value_o          = q_evt.value;
  assign last_blob_byte_o = q_evt.last;
  assign error_code_o     = q_evt.err;
endmodule

### hdl/tfd_checker.sv
// Port-level checks for the typed frame deframer.
module tfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        evt_valid_i,
  input logic        evt_stall_i,
  input logic [2:0]  event_kind_i,
  input logic [63:0] value_i,
  input logic        last_blob_byte_i,
  input logic [3:0]  error_code_i
);
  import tfd_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && evt_stall_i |=> evt_valid_i && $stable(value_i))
    else $error("stalled result changed");
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i |-> ((error_code_i != ER_NONE) == (event_kind_i == EV_ERR)))
    else $error("error code mismatch");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && last_blob_byte_i |-> event_kind_i == EV_BBYTE)
    else $error("last flag outside blob byte");
  a_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    evt_valid_i && (event_kind_i == EV_BBYTE || event_kind_i == EV_CMD)
      |-> value_i[63:8] == '0)
    else $error("byte result too wide");
endmodule

bind typed_frame_deframer_unit tfd_checker u_tfd_checker (
  .clk_i, .rst_ni, .evt_valid_i(evt_valid_o), .evt_stall_i,
  .event_kind_i(event_kind_o), .value_i(value_o),
  .last_blob_byte_i(last_blob_byte_o), .error_code_i(error_code_o)
);

### test/tb.sv
// Self-checking testbench for typed_frame_deframer_unit: directed frames, a random byte stream, then a sticky halt.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import tfd_pkg::*;

  localparam int CycleLimit = 600000;
  localparam logic [30:0] LenMax = 31'h7FFFFFFF;
  // argument tags
  localparam logic [7:0] TagF32 = 8'h54;
  localparam logic [7:0] TagF64 = 8'h58;
  localparam logic [7:0] TagStr = 8'h90;   // low nibble carries the prefix size
  localparam logic [7:0] TagBlob = 8'hB0;
  localparam logic [7:0] TagInt = 8'h30;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        rx_valid_i = 1'b0;
  logic        rx_stall_o;
  logic [7:0]  rx_byte_i = 8'h00;
  logic        evt_valid_o;
  logic        evt_stall_i = 1'b0;
  logic [2:0]  event_kind_o;
  logic [2:0]  arg_type_o;
  logic [63:0] value_o;
  logic        last_blob_byte_o;
  logic [3:0]  error_code_o;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [30:0] cfg_data_i = 31'd0;

  typed_frame_deframer_unit dut (.*);

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor: own copy of parser state and registers, updated per rx transfer.
  // ---------------------------------------------------------------------------
  phase_e      ph;
  logic [3:0]  fcnt;
  logic [31:0] lacc;
  logic [30:0] trem;
  logic [7:0]  csum;
  logic [7:0]  tag;
  logic [63:0] aval;
  logic [30:0] brem;
  logic [30:0] max_len;
  logic        stop_err;

  evt_t expected_evts[$];

  int n_bytes, n_checked, n_frames, n_errs_seen, n_fail;
  int cycles;
  bit calm;   // no gaps and no stalls while set

  task automatic queue_event(input event_e k, input arg_e t, input logic [63:0] v,
                             input logic l, input err_e e);
    evt_t ev;
    ev.kind = k;
    ev.atype = t;
    ev.value = v;
    ev.last = l;
    ev.err = e;
    expected_evts.push_back(ev);
    if (k == EV_OK) n_frames++;
    if (k == EV_ERR) n_errs_seen++;
  endtask

  task automatic predict_error(input err_e e);
    ph = PH_HALT;
    queue_event(EV_ERR, AT_INT, 64'd0, 1'b0, e);
  endtask

  function automatic phase_e after_item();
    return (trem == 31'd0) ? PH_ETX : PH_ATAG;
  endfunction

  task automatic predict_rx_byte(input logic [7:0] b);
    logic [3:0] sz;
    if (ph >= PH_CMD && ph <= PH_BBODY) begin
      csum = csum ^ b;
      trem = trem - 31'd1;
    end
    case (ph)
      PH_HALT: begin
        // hunting for SOH only when halting is not sticky
        if (!stop_err && b == ChSoh) ph = PH_LTAG;
      end
      PH_SOH: begin
        if (b != ChSoh) predict_error(ER_SOH);
        else ph = PH_LTAG;
      end
      PH_LTAG: begin
        if (b == 8'h11 || b == 8'h12 || b == 8'h14) begin
          tag = b;
          fcnt = b[3:0];
          lacc = 32'd0;
          ph = PH_LEN;
        end else predict_error(ER_LTAG);
      end
      PH_LEN: begin
        lacc = {lacc[23:0], b};
        fcnt = fcnt - 4'd1;
        if (fcnt == 4'd0) begin
          sz = tag[3:0];
          if (lacc[sz*8-1] || lacc == 32'd0 || lacc > {1'b0, max_len} || lacc[31])
            predict_error(ER_LEN);
          else begin
            trem = lacc[30:0];
            csum = 8'h00;
            ph = PH_STX;
          end
        end
      end
      PH_STX: begin
        if (b != ChStx) predict_error(ER_STX);
        else ph = PH_CMD;
      end
      PH_CMD: begin
        ph = after_item();
        queue_event(EV_CMD, AT_INT, {56'd0, b}, 1'b0, ER_NONE);
      end
      PH_ATAG: begin
        sz = b[3:0];
        if (b == 8'h31 || b == 8'h32 || b == 8'h34 || b == 8'h38 ||
            b == TagF32 || b == TagF64 || b == TagBool) begin
          if (b == TagBool) sz = 4'd1;
          if ({27'd0, sz} > trem) predict_error(ER_LEN);
          else begin
            tag = b;
            fcnt = sz;
            aval = 64'd0;
            ph = PH_AVAL;
          end
        end else if (b == 8'h91 || b == 8'h92 || b == 8'h94 ||
                     b == 8'hB1 || b == 8'hB2 || b == 8'hB4) begin
          if ({27'd0, sz} > trem) predict_error(ER_LEN);
          else begin
            tag = b;
            fcnt = sz;
            lacc = 32'd0;
            ph = PH_BLEN;
          end
        end else predict_error(ER_ATAG);
      end
      PH_AVAL: begin
        aval = {aval[55:0], b};
        fcnt = fcnt - 4'd1;
        if (fcnt == 4'd0) begin
          ph = after_item();
          sz = tag[3:0];
          if (tag[7:4] == 4'h3) begin
            if (sz < 4'd8 && aval[sz*8-1]) aval = aval | (~64'd0 << (sz * 8));
            queue_event(EV_SCALAR, AT_INT, aval, 1'b0, ER_NONE);
          end else if (tag[7:4] == 4'h5)
            queue_event(EV_SCALAR, (sz == 4'd4) ? AT_F32 : AT_F64, aval, 1'b0, ER_NONE);
          else
            queue_event(EV_SCALAR, AT_BOOL, {63'd0, aval[7:0] != 8'h00}, 1'b0, ER_NONE);
        end
      end
      PH_BLEN: begin
        lacc = {lacc[23:0], b};
        fcnt = fcnt - 4'd1;
        if (fcnt == 4'd0) begin
          sz = tag[3:0];
          if (lacc[sz*8-1] || lacc > {1'b0, trem}) predict_error(ER_LEN);
          else begin
            brem = lacc[30:0];
            ph = (brem != 31'd0) ? PH_BBODY : after_item();
            queue_event(EV_BSTART, (tag >= TagBlob) ? AT_BYTES : AT_STR,
                        {33'd0, brem}, 1'b0, ER_NONE);
          end
        end
      end
      PH_BBODY: begin
        brem = brem - 31'd1;
        if (brem == 31'd0) ph = after_item();
        queue_event(EV_BBYTE, (tag >= TagBlob) ? AT_BYTES : AT_STR, {56'd0, b},
                    brem == 31'd0, ER_NONE);
      end
      PH_ETX: begin
        if (b != ChEtx) predict_error(ER_ETX);
        else ph = PH_CHK;
      end
      PH_CHK: begin
        if (b != csum) predict_error(ER_CHK);
        else ph = PH_EOT;
      end
      PH_EOT: begin
        if (b != ChEot) predict_error(ER_EOT);
        else begin
          ph = PH_SOH;
          queue_event(EV_OK, AT_INT, 64'd0, 1'b0, ER_NONE);
        end
      end
      default: ph = PH_SOH;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Idle gaps: mostly none or short, now and then long.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side stall: random stretches of stall between ready cycles.
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stall_left <= 0;
      evt_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      evt_stall_i <= 1'b1;
    end else begin
      stall_left <= pick_gap();
      evt_stall_i <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every transfer on the event channel against the oldest
  // expectation.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    evt_t want;
    if (rst_ni && evt_valid_o && !evt_stall_i) begin
      if (expected_evts.size() == 0) begin
        $display("%0t: unexpected result kind=%0d value=%h err=%0d", $time,
                 event_kind_o, value_o, error_code_o);
        n_fail++;
      end else begin
        want = expected_evts.pop_front();
        n_checked++;
        if (event_kind_o !== want.kind) begin
          $display("%0t: event_kind exp %0d got %0d", $time, want.kind, event_kind_o);
          n_fail++;
        end
        if (arg_type_o !== want.atype) begin
          $display("%0t: arg_type exp %0d got %0d", $time, want.atype, arg_type_o);
          n_fail++;
        end
        if (value_o !== want.value) begin
          $display("%0t: value exp %h got %h", $time, want.value, value_o);
          n_fail++;
        end
        if (last_blob_byte_o !== want.last) begin
          $display("%0t: last_blob_byte exp %0b got %0b", $time, want.last,
                   last_blob_byte_o);
          n_fail++;
        end
        if (error_code_o !== want.err) begin
          $display("%0t: error_code exp %0d got %0d", $time, want.err, error_code_o);
          n_fail++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // One rx transfer; called and returning at a rising edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (rx_stall_o);
    predict_rx_byte(b);
    n_bytes++;
    gap = pick_gap();
    if (gap > 0) begin
      rx_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic send_bytes(input logic [7:0] bq[$]);
    foreach (bq[i]) send_byte(bq[i]);
  endtask

  // Stop sending, wait for every expected result, then let the pipe settle.
  task automatic drain();
    rx_valid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_evts.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [30:0] data);
    drain();
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgMaxLen) max_len = data;
    else stop_err = data[0];
  endtask

  task automatic put_be(ref logic [7:0] q[$], input logic [31:0] v, input int n);
    for (int i = n - 1; i >= 0; i--) q.push_back(v[i*8 +: 8]);
  endtask

  // Full frame around a text; declared length may differ from the text size.
  task automatic make_frame(input int lsize, input logic [31:0] len,
                            input logic [7:0] txt[$], output logic [7:0] fq[$]);
    logic [7:0] x;
    x = 8'h00;
    fq = {};
    fq.push_back(ChSoh);
    fq.push_back(8'h10 | lsize[7:0]);
    put_be(fq, len, lsize);
    fq.push_back(ChStx);
    foreach (txt[i]) begin
      fq.push_back(txt[i]);
      x ^= txt[i];
    end
    fq.push_back(ChEtx);
    fq.push_back(x);
    fq.push_back(ChEot);
  endtask

  task automatic send_text(input int lsize, input logic [7:0] txt[$]);
    logic [7:0] fq[$];
    make_frame(lsize, txt.size(), txt, fq);
    send_bytes(fq);
  endtask

  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h7F;
      default: return 8'($urandom);
    endcase
  endfunction

  // Command plus a random argument list; now and then a bogus tag.
  task automatic rand_text(output logic [7:0] txt[$]);
    int sz, n;
    txt = {};
    txt.push_back(rand_byte());
    repeat ($urandom_range(0, 4)) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          sz = 1 << $urandom_range(0, 3);
          txt.push_back(TagInt | sz[7:0]);
          repeat (sz) txt.push_back(rand_byte());
        end
        2: begin
          txt.push_back(TagF32);
          repeat (4) txt.push_back(rand_byte());
        end
        3: begin
          txt.push_back(TagF64);
          repeat (8) txt.push_back(rand_byte());
        end
        4: begin
          txt.push_back(TagBool);
          txt.push_back(rand_byte());
        end
        9: txt.push_back(8'($urandom));
        default: begin
          sz = 1 << $urandom_range(0, 2);
          n = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 4);
          txt.push_back(($urandom_range(0, 1) ? TagStr : TagBlob) | sz[7:0]);
          put_be(txt, n, sz);
          repeat (n) txt.push_back(8'($urandom));
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Well-formed frames covering every argument type and all three length sizes.
  task automatic test_valid_frames();
    logic [7:0] t[$];
    t = '{8'h00, 8'h31, 8'h80, 8'h32, 8'h7F, 8'hFF, 8'h34, 8'h80, 8'h00, 8'h00, 8'h01,
          8'h38, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFE,
          8'h54, 8'h3F, 8'h80, 8'h00, 8'h00,
          8'h58, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01,
          8'h71, 8'h00, 8'h71, 8'h80};
    send_text(2, t);
    // strings and byte arrays, the empty one included
    t = '{8'hFF, 8'h91, 8'h01, 8'hAA, 8'hB2, 8'h00, 8'h00, 8'h94, 8'h00, 8'h00, 8'h00,
          8'h02, 8'h55, 8'h00, 8'hB1, 8'h00};
    send_text(4, t);
    t = '{8'h41};
    send_text(1, t);
    drain();
  endtask

  // One frame per framing error, each followed by resync on the next SOH.
  task automatic test_framing_errors();
    write_reg(CfgStop, 31'd0);
    send_bytes('{8'hC5});                                          // noise between frames
    send_bytes('{8'h01, 8'h13});                                   // bad length tag
    send_bytes('{8'h01, 8'h11, 8'h01, 8'h05});                     // missing STX
    send_bytes('{8'h01, 8'h11, 8'h01, 8'h02, 8'h41, 8'h05});       // missing ETX
    send_bytes('{8'h01, 8'h11, 8'h02, 8'h02, 8'h41, 8'h20});       // bad argument tag
    send_bytes('{8'h01, 8'h11, 8'h01, 8'h02, 8'h41, 8'h03, 8'h00}); // bad checksum
    send_bytes('{8'h01, 8'h11, 8'h01, 8'h02, 8'h41, 8'h03, 8'h41, 8'h05}); // no EOT
    send_text(1, '{8'h42});
    drain();
  endtask

  // Zero, negative and too large text lengths against several limits.
  task automatic test_bad_lengths();
    send_bytes('{8'h01, 8'h11, 8'h00});
    send_bytes('{8'h01, 8'h11, 8'h80});
    send_bytes('{8'h01, 8'h12, 8'h80, 8'h00});
    send_bytes('{8'h01, 8'h14, 8'hFF, 8'hFF, 8'hFF, 8'hFF});
    write_reg(CfgMaxLen, 31'd5);
    send_bytes('{8'h01, 8'h11, 8'h06});
    send_text(1, '{8'h10, 8'h71, 8'h01, 8'h31, 8'h7F});
    write_reg(CfgMaxLen, 31'd0);
    send_text(1, '{8'h10});
    write_reg(CfgMaxLen, 31'd1);
    send_text(1, '{8'h11});
    send_text(1, '{8'h11, 8'hB1, 8'h00});
    write_reg(CfgMaxLen, LenMax - 31'd1);
    send_bytes('{8'h01, 8'h14, 8'h7F, 8'hFF, 8'hFF, 8'hFF});
    write_reg(CfgMaxLen, LenMax);
  endtask

  // Arguments that run past the end of the text, and a negative blob length.
  task automatic test_overruns();
    send_bytes('{8'h01, 8'h11, 8'h02, 8'h02, 8'h41, 8'h32});             // scalar
    send_bytes('{8'h01, 8'h11, 8'h02, 8'h02, 8'h41, 8'h92});             // length prefix
    send_bytes('{8'h01, 8'h11, 8'h03, 8'h02, 8'h41, 8'h91, 8'h05});      // blob body
    send_bytes('{8'h01, 8'h11, 8'h04, 8'h02, 8'h41, 8'hB2, 8'hFF, 8'hFF}); // negative
    send_text(1, '{8'h43});
    drain();
  endtask

  // Mostly clean frames with random content, some damaged, some noise.
  task automatic test_random_stream();
    logic [7:0] txt[$], fq[$];
    int lsize, k, batch;
    batch = 0;
    while (n_bytes < 1450) begin
      if (n_bytes / 200 != batch) begin
        batch = n_bytes / 200;
        calm = ($urandom_range(0, 3) == 0);
        case ($urandom_range(0, 5))
          0: write_reg(CfgMaxLen, 31'($urandom_range(3, 40)));
          1: write_reg(CfgMaxLen, 31'($urandom_range(1, 2)));
          default: write_reg(CfgMaxLen, LenMax);
        endcase
      end
      if ($urandom_range(0, 99) < 10) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else begin
        rand_text(txt);
        lsize = (txt.size() > 127) ? 2 : (1 << $urandom_range(0, 2));
        make_frame(lsize, txt.size(), txt, fq);
        if ($urandom_range(0, 99) < 15) begin
          k = $urandom_range(0, fq.size() - 1);
          case ($urandom_range(0, 2))
            0: fq[k] = fq[k] ^ (8'h01 << $urandom_range(0, 7));
            1: fq.delete(k);
            default: make_frame(lsize, txt.size() - $urandom_range(1, 3), txt, fq);
          endcase
        end
        send_bytes(fq);
      end
    end
    calm = 0;
    drain();
  endtask

  // Sticky halt: once in error, even a fresh SOH yields nothing.
  task automatic test_sticky_halt();
    write_reg(CfgStop, 31'd1);
    send_bytes('{8'h7E, 8'h01, 8'h11, 8'h01, 8'h02, 8'h41, 8'h03, 8'h41, 8'h04});
    drain();
  endtask

  initial begin
    ph = PH_SOH;
    fcnt = '0;
    lacc = '0;
    trem = '0;
    csum = '0;
    tag = '0;
    aval = '0;
    brem = '0;
    max_len = LenMax;
    stop_err = 1'b1;
    calm = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_valid_frames();
    test_framing_errors();
    test_bad_lengths();
    test_overruns();
    test_random_stream();
    test_sticky_halt();

    $display("tb: %0d bytes sent, %0d results checked", n_bytes, n_checked);
    $display("tb: %0d good frames, %0d error reports", n_frames, n_errs_seen);
    if (n_fail == 0 && expected_evts.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
